[src/bctp_pkg.sv]
// shared types and constants for the capability tlv parser
`default_nettype none

package bctp_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam logic [7:0] CAP_PARAM_TYPE = 8'd2;

   typedef enum logic [6:0] {
      PH_STOP  = 7'b0000001,
      PH_PTYPE = 7'b0000010,
      PH_PLEN  = 7'b0000100,
      PH_SKIP  = 7'b0001000,
      PH_CCODE = 7'b0010000,
      PH_CLEN  = 7'b0100000,
      PH_CVAL  = 7'b1000000
   } phase_type;

   localparam logic KIND_HEADER = 1'b0;
   localparam logic KIND_VALUE  = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [7:0] code;
      logic [7:0] length;
      logic [7:0] vbyte;
      logic [7:0] vidx;
      logic       last;
   } result_type;

endpackage

`default_nettype wire

[src/bctp_front.sv]
// front end: walks the parameter and capability structure one byte per transfer
`default_nettype none

module bctp_front (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 in_valid,
   output logic                in_ready,
   input  wire  [7:0]          data_byte,
   input  wire                 block_start,
   input  wire  [7:0]          block_len,
   output logic                push_valid,
   input  wire                 push_ready,
   output bctp_pkg::result_type push_data
);
   import bctp_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [7:0] blk_ff, blk_in;
   logic [7:0] prm_ff, prm_in;
   logic       incap_ff, incap_in;
   logic [7:0] code_ff, code_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] vc_ff, vc_in;

   logic       accept;
   logic       emit;
   result_type res;

   assign in_ready   = push_ready;
   assign accept     = in_valid & in_ready;
   assign push_valid = accept & emit;
   assign push_data  = res;

   always_comb begin
      phase_type  ph;
      logic [7:0] blk;
      logic [7:0] prm;
      logic       incap;
      logic [7:0] left;
      logic [7:0] prm_dec;
      logic       last;

      ph    = phase_ff;
      blk   = blk_ff;
      prm   = prm_ff;
      incap = incap_ff;
      if (block_start) begin
         blk   = block_len;
         prm   = 8'd0;
         incap = 1'b0;
         ph    = (block_len == 8'd0) ? PH_STOP : PH_PTYPE;
      end
      left     = blk - 8'd1;
      prm_dec  = prm - 8'd1;
      last     = ({1'b0, vc_ff} + 9'd1) >= {1'b0, len_ff};

      phase_in = ph;
      blk_in   = blk;
      prm_in   = prm;
      incap_in = incap;
      code_in  = code_ff;
      len_in   = len_ff;
      vc_in    = vc_ff;
      emit     = 1'b0;
      res      = '0;

      if (ph == PH_STOP || blk == 8'd0) begin
         phase_in = PH_STOP;
      end else begin
         blk_in = left;
         case (ph)
            PH_PTYPE: begin
               if (blk < 8'd2) begin
                  phase_in = PH_STOP;
               end else begin
                  incap_in = (data_byte == CAP_PARAM_TYPE);
                  prm_in   = 8'd0;
                  phase_in = PH_PLEN;
               end
            end
            PH_PLEN: begin
               if (data_byte > left) begin
                  phase_in = PH_STOP;
               end else begin
                  prm_in = data_byte;
                  if (data_byte == 8'd0)
                     phase_in = PH_PTYPE;
                  else
                     phase_in = incap ? PH_CCODE : PH_SKIP;
               end
            end
            PH_SKIP: begin
               prm_in = prm_dec;
               if (prm_dec == 8'd0)
                  phase_in = PH_PTYPE;
            end
            PH_CCODE: begin
               // a lone byte left in the parameter is reread as a parameter type
               if (prm < 8'd2) begin
                  if (blk < 8'd2) begin
                     phase_in = PH_STOP;
                  end else begin
                     incap_in = (data_byte == CAP_PARAM_TYPE);
                     prm_in   = 8'd0;
                     phase_in = PH_PLEN;
                  end
               end else begin
                  code_in  = data_byte;
                  prm_in   = prm_dec;
                  phase_in = PH_CLEN;
               end
            end
            PH_CLEN: begin
               if (data_byte > prm_dec) begin
                  prm_in   = 8'd0;
                  phase_in = PH_PTYPE;
               end else begin
                  prm_in     = prm_dec;
                  len_in     = data_byte;
                  vc_in      = 8'd0;
                  emit       = 1'b1;
                  res.kind   = KIND_HEADER;
                  res.code   = code_ff;
                  res.length = data_byte;
                  res.vbyte  = 8'd0;
                  res.vidx   = 8'd0;
                  res.last   = (data_byte == 8'd0);
                  if (data_byte == 8'd0)
                     phase_in = (prm_dec == 8'd0) ? PH_PTYPE : PH_CCODE;
                  else
                     phase_in = PH_CVAL;
               end
            end
            PH_CVAL: begin
               prm_in     = (prm != 8'd0) ? prm_dec : prm;
               emit       = 1'b1;
               res.kind   = KIND_VALUE;
               res.code   = code_ff;
               res.length = len_ff;
               res.vbyte  = data_byte;
               res.vidx   = vc_ff;
               res.last   = last;
               vc_in      = vc_ff + 8'd1;
               if (last)
                  phase_in = (prm_in == 8'd0) ? PH_PTYPE : PH_CCODE;
            end
            default: begin
               phase_in = PH_STOP;
            end
         endcase
         if (left == 8'd0)
            phase_in = PH_STOP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_STOP;
         blk_ff   <= 8'd0;
         prm_ff   <= 8'd0;
         incap_ff <= 1'b0;
         code_ff  <= 8'd0;
         len_ff   <= 8'd0;
         vc_ff    <= 8'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         blk_ff   <= blk_in;
         prm_ff   <= prm_in;
         incap_ff <= incap_in;
         code_ff  <= code_in;
         len_ff   <= len_in;
         vc_ff    <= vc_in;
      end
   end

endmodule

`default_nettype wire

[src/bctp_queue.sv]
// short result queue between the parser front end and the output stage
`default_nettype none

module bctp_queue #(
   parameter int unsigned DEPTH = bctp_pkg::QUEUE_DEPTH
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push_valid,
   output logic                 push_ready,
   input  bctp_pkg::result_type push_data,
   output logic                 pop_valid,
   input  wire                  pop_ready,
   output bctp_pkg::result_type pop_data
);
   import bctp_pkg::*;

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   result_type     mem_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           do_push, do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
      if (do_push && !do_pop)
         count_in = count_ff + CW'(1);
      else if (do_pop && !do_push)
         count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push)
         mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

`default_nettype wire

[src/bctp_back.sv]
// output stage: drains the queue into the registered result channel
`default_nettype none

module bctp_back (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  pop_valid,
   output logic                 pop_ready,
   input  bctp_pkg::result_type pop_data,
   output logic                 out_valid,
   input  wire                  out_ready,
   output bctp_pkg::result_type out_data
);
   import bctp_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   // reload whenever the held result leaves or the register is empty
   assign pop_ready = ~valid_ff | out_ready;
   assign valid_in  = pop_valid | (valid_ff & ~out_ready);
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else
         valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (pop_valid && pop_ready)
         data_ff <= pop_data;
   end

endmodule

`default_nettype wire

[src/bgp_capability_tlv_parser.sv]
// top level of the bgp open capability parameter parser
//
//   channel   dir   tdata                                        tuser        tlast
//   req_      in    [7:0] data_byte, [15:8] block_len            block_start  -
//   rsp_      out   [7:0] cap_id, [15:8] cap_length,             item_kind    cap_last
//                   [23:16] value_byte, [31:24] value_index
//
// one byte is taken per cycle while the queue has room; the parser decides each byte combinationally
// a result reaches rsp_ by way of the queue and then the output register: parser into queue, queue into output register
// synchronous reset empties the queue and output register and stops parsing until a block start
// req_tready falls only when the queue is full, i.e. after rsp_tready has been low for a while
`default_nettype none

module bgp_capability_tlv_parser #(
   parameter int unsigned QUEUE_DEPTH = bctp_pkg::QUEUE_DEPTH
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,   // data_byte, block_len
   input  wire         req_tuser,   // block_start
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,   // cap_id, cap_length, value_byte, value_index
   output logic        rsp_tuser,   // item_kind
   output logic        rsp_tlast    // cap_last
);
   import bctp_pkg::*;

   logic       push_valid, push_ready;
   result_type push_data;
   logic       pop_valid, pop_ready;
   result_type pop_data;
   result_type out_data;

   bctp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .data_byte   (req_tdata[7:0]),
      .block_start (req_tuser),
      .block_len   (req_tdata[15:8]),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_data   (push_data)
   );

   bctp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   bctp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tdata = {out_data.vidx, out_data.vbyte, out_data.length, out_data.code};
   assign rsp_tuser = out_data.kind;
   assign rsp_tlast = out_data.last;

   // an empty block start never yields a result
   a_empty_block: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser && req_tdata[15:8] == 8'd0) |-> !push_valid)
      else $error("result from an empty block");

   a_zero_len_header: assert property (@(posedge clock) disable iff (reset)
      (push_valid && push_data.kind == KIND_HEADER && push_data.length == 8'd0)
         |-> push_data.last)
      else $error("zero-length capability header not marked last");

   a_value_index: assert property (@(posedge clock) disable iff (reset)
      (push_valid && push_data.kind == KIND_VALUE) |-> (push_data.vidx < push_data.length))
      else $error("value index beyond capability length");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

`default_nettype wire
